### rtl/skc_pkg.sv
// ---------------------------------------------------------------------------
// skc_pkg
// types and constants shared by the sorted key counter table
// ---------------------------------------------------------------------------
package skc_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int KEY_W        = 16;
  localparam int CNT_W        = 32;

  typedef enum logic [1:0] {
    MODE_INC = 2'd0,
    MODE_DEC = 2'd1,
    MODE_SET = 2'd2,
    MODE_GET = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_CMP  = 2'd1,
    ST_RD   = 2'd2,
    ST_UPD  = 2'd3
  } state_t;

  typedef struct packed {
    logic              cmp;
    logic              wr;
    logic              ins;
    logic [KEY_W-1:0]  key;
    logic [CNT_W-1:0]  value;
  } skc_cmd_t;

endpackage

### rtl/sorted_key_counter_table_core.sv
// ---------------------------------------------------------------------------
// sorted_key_counter_table_core
// table of saturating counters kept in ascending key order in a row of cells
// ---------------------------------------------------------------------------
// input beats carry an operation (increment, decrement, set, get) in
// in_tuser and a key and amount in in_tdata. each input beat gives exactly
// one output beat with the counter value in out_tdata and the found and
// full flags in out_tuser.
// an item goes through these steps in order: accept, the key compare in
// every cell, gathering the matching counter, and the add and the write
// back or the one-step shift that inserts a new key. the block takes no new
// beat until the item has left its update step.
// the output register holds a finished beat while the next item is accepted
// and worked on; if the receiver stalls, the item waits in its update step
// until the output register frees up, and the table is not touched before.
// reset empties the table (entry count to zero) and clears the handshakes;
// the block takes an item in the first cycle after reset.
// ---------------------------------------------------------------------------
module sorted_key_counter_table_core
  import skc_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // key[15:0], amount[47:16]
  input  logic [1:0]  in_tuser,   // mode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // count_value[31:0]
  output logic [1:0]  out_tuser   // key_found[0], table_full[1]
);

  localparam int CW = $clog2(CAPACITY + 1);

  state_t           state_r, state_nxt;
  mode_t            mode_r;
  logic [KEY_W-1:0] ikey_r;
  logic [CNT_W-1:0] amt_r;
  logic [CW-1:0]    used_r, used_nxt;
  logic             found_r;
  logic [CNT_W-1:0] cur_r;
  logic             out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0] out_cnt_r;
  logic             out_found_r;
  logic             out_full_r;

  skc_cmd_t         cmd;
  logic             in_acc;
  logic             out_free;
  logic             upd_go;
  logic             full;
  logic [CNT_W-1:0] res;
  logic             res_full;
  logic             do_wr;
  logic             do_ins;
  logic [CNT_W:0]   sum_inc, sum_dec;
  logic [CNT_W-1:0] sat_inc, sat_dec;
  logic             eq_any;
  logic [CNT_W-1:0] rd_cnt;

  logic [CAPACITY-1:0] valid_v, ge_v, eq_v, pos_v;
  logic [KEY_W-1:0]    key_v [CAPACITY];
  logic [CNT_W-1:0]    cnt_v [CAPACITY];
  logic [CNT_W-1:0]    sel_v [CAPACITY];

  // cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      skc_cell #(.CW(CW), .IDX(i)) u_cell (
        .clk, .rst_n, .cmd, .used(used_r),
        .left_ge(1'b0), .left_valid(1'b1),
        .left_key('0), .left_cnt('0),
        .valid(valid_v[i]), .ge(ge_v[i]), .eq(eq_v[i]), .at_pos(pos_v[i]),
        .key(key_v[i]), .cnt(cnt_v[i]), .sel_cnt(sel_v[i])
      );
    end else begin : g_rest
      skc_cell #(.CW(CW), .IDX(i)) u_cell (
        .clk, .rst_n, .cmd, .used(used_r),
        .left_ge(ge_v[i-1]), .left_valid(valid_v[i-1]),
        .left_key(key_v[i-1]), .left_cnt(cnt_v[i-1]),
        .valid(valid_v[i]), .ge(ge_v[i]), .eq(eq_v[i]), .at_pos(pos_v[i]),
        .key(key_v[i]), .cnt(cnt_v[i]), .sel_cnt(sel_v[i])
      );
    end
  end

  always_comb begin
    rd_cnt = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_cnt = rd_cnt | sel_v[i];
    end
  end
  assign eq_any = |eq_v;

  assign in_tready = (state_r == ST_IDLE) && rst_n;
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign upd_go    = (state_r == ST_UPD) && out_free;
  assign full      = (used_r == CW'(CAPACITY));

  // saturating arithmetic
  assign sum_inc = {cur_r[CNT_W-1], cur_r} + {amt_r[CNT_W-1], amt_r};
  assign sum_dec = {cur_r[CNT_W-1], cur_r} - {amt_r[CNT_W-1], amt_r};
  assign sat_inc = (sum_inc[CNT_W] != sum_inc[CNT_W-1])
                   ? {sum_inc[CNT_W], {(CNT_W-1){!sum_inc[CNT_W]}}}
                   : sum_inc[CNT_W-1:0];
  always_comb begin
    if (sum_dec[CNT_W] != sum_dec[CNT_W-1]) begin
      sat_dec = sum_dec[CNT_W] ? '0 : {1'b0, {(CNT_W-1){1'b1}}};
    end else if (sum_dec[CNT_W-1]) begin
      sat_dec = '0;
    end else begin
      sat_dec = sum_dec[CNT_W-1:0];
    end
  end

  always_comb begin
    res      = '0;
    res_full = 1'b0;
    do_wr    = 1'b0;
    do_ins   = 1'b0;
    if (found_r) begin
      case (mode_r)
        MODE_INC: begin res = sat_inc; do_wr = 1'b1; end
        MODE_DEC: begin res = sat_dec; do_wr = 1'b1; end
        MODE_SET: begin res = amt_r;   do_wr = 1'b1; end
        default:  res = cur_r;
      endcase
    end else if (mode_r == MODE_INC || mode_r == MODE_SET) begin
      if (full) begin
        res_full = 1'b1;
      end else begin
        res    = amt_r;
        do_ins = 1'b1;
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_CMP;
      ST_CMP:  state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_UPD;
      ST_UPD:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // cell commands
  always_comb begin
    cmd.cmp   = 1'b0;
    cmd.wr    = 1'b0;
    cmd.ins   = 1'b0;
    cmd.key   = ikey_r;
    cmd.value = res;
    case (state_r)
      ST_CMP:  cmd.cmp = 1'b1;
      ST_UPD: begin
        cmd.wr  = upd_go && do_wr;
        cmd.ins = upd_go && do_ins;
      end
      default: ;
    endcase
  end

  assign used_nxt = cmd.ins ? used_r + CW'(1) : used_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (upd_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r <= mode_t'(in_tuser);
      ikey_r <= in_tdata[15:0];
      amt_r  <= in_tdata[47:16];
    end
    if (state_r == ST_RD) begin
      found_r <= eq_any;
      cur_r   <= rd_cnt;
    end
    if (upd_go) begin
      out_cnt_r   <= res;
      out_found_r <= found_r;
      out_full_r  <= res_full;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_cnt_r;
  assign out_tuser  = {out_full_r, out_found_r};

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_one_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(eq_v))
    else $error("key matches more than one cell");

  a_one_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins |-> $onehot(pos_v))
    else $error("insert without a single target cell");

  a_used_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (used_r != $past(used_r)) |-> $past(cmd.ins))
    else $error("entry count changed without insert");

  a_full_beat: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) && out_tuser[1] |-> !out_tuser[0] && out_tdata == '0)
    else $error("dropped insert reports a value");
`endif

endmodule

### rtl/skc_cell.sv
// ---------------------------------------------------------------------------
// skc_cell
// one table slot: key, counter, compare flags and shift from left neighbor
// ---------------------------------------------------------------------------
module skc_cell
  import skc_pkg::*;
#(
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  skc_cmd_t         cmd,
  input  logic [CW-1:0]    used,
  input  logic             left_ge,
  input  logic             left_valid,
  input  logic [KEY_W-1:0] left_key,
  input  logic [CNT_W-1:0] left_cnt,
  output logic             valid,
  output logic             ge,
  output logic             eq,
  output logic             at_pos,
  output logic [KEY_W-1:0] key,
  output logic [CNT_W-1:0] cnt,
  output logic [CNT_W-1:0] sel_cnt
);

  logic             ge_r, ge_nxt;
  logic             eq_r, eq_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign valid   = (CW'(IDX) < used);
  assign ge      = ge_r;
  assign eq      = eq_r;
  assign key     = key_r;
  assign cnt     = cnt_r;
  assign sel_cnt = eq_r ? cnt_r : '0;
  assign at_pos  = !left_ge && left_valid && (ge_r || !valid);

  always_comb begin
    ge_nxt  = ge_r;
    eq_nxt  = eq_r;
    key_nxt = key_r;
    cnt_nxt = cnt_r;
    if (cmd.cmp) begin
      ge_nxt = valid && (key_r >= cmd.key);
      eq_nxt = valid && (key_r == cmd.key);
    end
    if (cmd.wr && eq_r) begin
      cnt_nxt = cmd.value;
    end
    if (cmd.ins) begin
      if (at_pos) begin
        key_nxt = cmd.key;
        cnt_nxt = cmd.value;
      end else if (left_ge) begin
        key_nxt = left_key;
        cnt_nxt = left_cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ge_r <= 1'b0;
      eq_r <= 1'b0;
    end else begin
      ge_r <= ge_nxt;
      eq_r <= eq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    cnt_r <= cnt_nxt;
  end

endmodule

### dv/sorted_key_counter_table_core_tb.sv
// ---------------------------------------------------------------------------
// sorted_key_counter_table_core_tb
// self-checking bench for the sorted key counter table
// ---------------------------------------------------------------------------
// drives increment, decrement, set and get beats into the table and keeps a
// shadow copy of the sorted table to work out each output beat. covers
// insert at the front, middle and end, saturation at both bounds, the
// decrement floor, absent keys, dropped inserts into a full table, random
// gaps on both sides, a stretch with no gaps and a long output stall.
// ---------------------------------------------------------------------------
module sorted_key_counter_table_core_tb
  import skc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     CAPACITY    = CAPACITY_DEF;
  localparam int     HOLD_CYCLES = 300;
  localparam int     CYCLE_LIMIT = 400000;
  localparam longint CNT_MAX     = 64'sd2147483647;
  localparam longint CNT_MIN     = -64'sd2147483648;

  typedef struct packed {
    logic signed [CNT_W-1:0] count_value;
    logic                    key_found;
    logic                    table_full;
  } counter_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;   // key[15:0], amount[47:16]
  logic [1:0]  in_tuser   = '0;   // mode[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // count_value[31:0]
  logic [1:0]  out_tuser;         // key_found[0], table_full[1]

  // shadow of the table contents
  logic [KEY_W-1:0]        shadow_keys   [CAPACITY];
  logic signed [CNT_W-1:0] shadow_counts [CAPACITY];
  int                      shadow_used = 0;

  counter_result_t expected_counts[$];

  bit tx_idle_en  = 1'b1;
  bit rx_idle_en  = 1'b1;
  int hold_asks   = 0;
  int hold_seen   = 0;
  int hold_left   = 0;
  int cycle_count = 0;
  int fail_count  = 0;
  int items_sent  = 0;
  int results_checked = 0;
  int drops_seen  = 0;

  sorted_key_counter_table_core #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_counts.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: random stalls plus a long hold on request
  always @(posedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen  <= hold_asks;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (rx_idle_en) begin
      out_tready <= ($urandom_range(0, 99) >= 32);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // output beat check
  always @(posedge clk) begin
    counter_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_checked <= results_checked + 1;
      if (expected_counts.size() == 0) begin
        $error("unexpected output beat: count_value %0d", $signed(out_tdata));
        fail_count = fail_count + 1;
      end else begin
        want = expected_counts.pop_front();
        if (out_tdata !== want.count_value) begin
          $error("count_value mismatch: expected %0d, got %0d", want.count_value,
                 $signed(out_tdata));
          fail_count = fail_count + 1;
        end
        if (out_tuser[0] !== want.key_found) begin
          $error("key_found mismatch: expected %0b, got %0b", want.key_found,
                 out_tuser[0]);
          fail_count = fail_count + 1;
        end
        if (out_tuser[1] !== want.table_full) begin
          $error("table_full mismatch: expected %0b, got %0b", want.table_full,
                 out_tuser[1]);
          fail_count = fail_count + 1;
        end
      end
    end
  end

  function automatic int find_slot(logic [KEY_W-1:0] k);
    int pos;
    pos = 0;
    while (pos < shadow_used && shadow_keys[pos] < k) pos++;
    return pos;
  endfunction

  function automatic logic signed [CNT_W-1:0] clamp_count(longint v);
    if (v > CNT_MAX) return CNT_MAX[CNT_W-1:0];
    if (v < CNT_MIN) return CNT_MIN[CNT_W-1:0];
    return v[CNT_W-1:0];
  endfunction

  function automatic counter_result_t apply_counter_op(mode_t m, logic [KEY_W-1:0] k,
                                                       logic signed [CNT_W-1:0] a);
    counter_result_t         r;
    int                      pos;
    logic signed [CNT_W-1:0] cur;
    r   = '0;
    pos = find_slot(k);
    r.key_found = (pos < shadow_used) && (shadow_keys[pos] == k);
    if (r.key_found) begin
      cur = shadow_counts[pos];
      case (m)
        MODE_INC: cur = clamp_count(longint'(cur) + longint'(a));
        MODE_DEC: begin
          cur = clamp_count(longint'(cur) - longint'(a));
          if (cur <= 0) cur = '0;
        end
        MODE_SET: cur = a;
        default: ;
      endcase
      shadow_counts[pos] = cur;
      r.count_value      = cur;
    end else if (m == MODE_INC || m == MODE_SET) begin
      if (shadow_used < CAPACITY) begin
        for (int i = shadow_used; i > pos; i--) begin
          shadow_keys[i]   = shadow_keys[i-1];
          shadow_counts[i] = shadow_counts[i-1];
        end
        shadow_keys[pos]   = k;
        shadow_counts[pos] = a;
        shadow_used++;
        r.count_value = a;
      end else begin
        r.table_full = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic send_op(mode_t m, logic [KEY_W-1:0] k, logic [CNT_W-1:0] a);
    counter_result_t r;
    while (tx_idle_en && $urandom_range(0, 99) < 32) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {a, k};
    in_tuser  <= m;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = apply_counter_op(m, k, a);
    if (r.table_full) drops_seen++;
    expected_counts.insert(expected_counts.size(), r);
    items_sent++;
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    if (shadow_used != 0 && $urandom_range(0, 99) < 70)
      return shadow_keys[$urandom_range(0, shadow_used - 1)];
    return KEY_W'($urandom);
  endfunction

  function automatic logic [CNT_W-1:0] pick_amount();
    case ($urandom_range(0, 5))
      0:       return 32'h7FFF_FFFF - $urandom_range(0, 3);
      1:       return 32'h8000_0000 + $urandom_range(0, 3);
      2:       return $urandom;
      3, 4:    return CNT_W'($urandom_range(0, 200) - 100);
      default: return '0;
    endcase
  endfunction

  task automatic test_directed_ops();
    send_op(MODE_GET, 16'h1234, 32'd9);
    send_op(MODE_DEC, 16'h1234, 32'd9);
    send_op(MODE_INC, 16'h8000, 32'd5);
    send_op(MODE_INC, 16'hFFFF, 32'h7FFF_FFFF);
    send_op(MODE_INC, 16'h0000, -32'sd7);
    send_op(MODE_INC, 16'hFFFF, 32'd1);
    send_op(MODE_DEC, 16'hFFFF, 32'hFFFF_FFFF);
    send_op(MODE_SET, 16'h0000, 32'h8000_0000);
    send_op(MODE_INC, 16'h0000, 32'hFFFF_FFFF);
    send_op(MODE_DEC, 16'h0000, 32'd1);
    send_op(MODE_DEC, 16'h8000, 32'd5);
    send_op(MODE_DEC, 16'h8000, 32'h7FFF_FFFF);
    send_op(MODE_SET, 16'h4000, 32'd123);
    send_op(MODE_SET, 16'h4000, 32'hFFFF_FFFF);
    send_op(MODE_GET, 16'h4000, 32'h5555_5555);
    send_op(MODE_GET, 16'hFFFF, 32'hAAAA_AAAA);
    send_op(MODE_DEC, 16'h4000, 32'h8000_0000);
    send_op(MODE_INC, 16'h8000, 32'h8000_0000);
    send_op(MODE_GET, 16'h7FFF, 32'd0);
  endtask

  task automatic test_random_ops(int n);
    repeat (n) send_op(mode_t'($urandom_range(0, 3)), pick_key(), pick_amount());
  endtask

  task automatic test_back_to_back(int n);
    tx_idle_en = 1'b0;
    rx_idle_en <= 1'b0;
    test_random_ops(n);
    tx_idle_en = 1'b1;
    rx_idle_en <= 1'b1;
  endtask

  task automatic test_table_full();
    logic [KEY_W-1:0] k;
    while (shadow_used < CAPACITY) send_op(MODE_SET, KEY_W'($urandom), pick_amount());
    repeat (3) begin
      do k = KEY_W'($urandom); while (find_slot(k) < shadow_used &&
                                      shadow_keys[find_slot(k)] == k);
      send_op(MODE_INC, k, pick_amount());
      send_op(MODE_SET, k, pick_amount());
      send_op(MODE_DEC, k, pick_amount());
      send_op(MODE_GET, k, pick_amount());
    end
    send_op(MODE_INC, shadow_keys[0], 32'd1);
    send_op(MODE_GET, shadow_keys[CAPACITY-1], 32'd0);
  endtask

  task automatic test_output_stall(int n);
    tx_idle_en = 1'b0;
    hold_asks <= hold_asks + 1;
    test_random_ops(n);
    tx_idle_en = 1'b1;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_ops();
    test_random_ops(700);
    test_back_to_back(250);
    test_table_full();
    test_output_stall(60);
    test_random_ops(200);
    in_tvalid <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("sent %0d beats of all four operations, %0d output beats checked",
             items_sent, results_checked);
    $display("%0d inserts dropped on a full table, incl. a %0d-cycle output stall",
             drops_seen, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### files.f
rtl/skc_pkg.sv
rtl/skc_cell.sv
rtl/sorted_key_counter_table_core.sv
dv/sorted_key_counter_table_core_tb.sv
